[design/rra_pkg.sv]
package rra_pkg;

    localparam int CALC_W     = 34;
    localparam int SIZE_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ACT_W      = 2;
    localparam int KIND_W     = 3;
    localparam int SHIFT_W    = 5;
    localparam int COUNT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_ADDRESS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ADDRESS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_BITS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_BITS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BLOCKS   = 3'd5;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_DEALLOC = 2'd1,
        ACT_FLUSH   = 2'd2,
        ACT_QUERY   = 2'd3
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOCATED = 3'd0,
        KIND_REFUSED   = 3'd1,
        KIND_RELEASED  = 3'd2,
        KIND_ADDRESS   = 3'd3,
        KIND_DONE      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        RD_NEWEST = 2'd0,
        RD_WALK   = 2'd1,
        RD_FRESH  = 2'd2,
        RD_INDEX  = 2'd3
    } rd_sel_t;

    typedef struct packed {
        logic    latch_in;
        logic    prep;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    calc_search;
        logic    calc_adj;
        logic    walk_evict;
        logic    tag_clear;
        logic    retry_window;
        logic    fail_commit;
        logic    commit;
        logic    flush_step;
        logic    flush_end;
        logic    emit;
        kind_t   emit_kind;
        logic    emit_last;
        logic    emit_row;
    } dp_cmd_t;

    typedef struct packed {
        logic ring_used;
        logic too_large;
        logic walking;
        logic walk_hit;
        logic tag_nz;
        logic fits;
        logic from_newest;
        logic walk_at_newest;
        logic bad_index;
        logic out_free;
    } dp_status_t;

endpackage

[design/rra_ctrl.sv]
module rra_ctrl
    import rra_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  action_t    in_action,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [16:0] {
        ST_IDLE   = 17'h00001,
        ST_PREP   = 17'h00002,
        ST_SEARCH = 17'h00004,
        ST_ADJ    = 17'h00008,
        ST_WRD    = 17'h00010,
        ST_WALK   = 17'h00020,
        ST_CHECK  = 17'h00040,
        ST_FAIL   = 17'h00080,
        ST_PRD    = 17'h00100,
        ST_PLACE  = 17'h00200,
        ST_COMMIT = 17'h00400,
        ST_FRD    = 17'h00800,
        ST_FLUSH  = 17'h01000,
        ST_DONEF  = 17'h02000,
        ST_IRD    = 17'h04000,
        ST_IDX    = 17'h08000,
        ST_IDONE  = 17'h10000
    } state_t;

    state_t  state_reg, state_next;
    action_t act_reg, act_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            act_reg   <= ACT_ALLOC;
        end else begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        act_next   = act_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.latch_in = 1'b1;
                    act_next     = in_action;
                    unique case (in_action)
                        ACT_ALLOC:   state_next = ST_PREP;
                        ACT_FLUSH:   state_next = status.ring_used ? ST_FRD : ST_DONEF;
                        default:     state_next = ST_IRD;
                    endcase
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NEWEST;
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (status.too_large) begin
                    if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_REFUSED;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.calc_search = 1'b1;
                    state_next      = ST_ADJ;
                end
            end
            ST_ADJ: begin
                cmd.calc_adj = 1'b1;
                state_next   = ST_WRD;
            end
            ST_WRD: begin
                if (status.walking) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_WALK;
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_WALK: begin
                if (!status.walk_hit) begin
                    state_next = ST_CHECK;
                end else if (!status.tag_nz || status.out_free) begin
                    cmd.emit       = status.tag_nz;
                    cmd.emit_kind  = KIND_RELEASED;
                    cmd.emit_row   = 1'b1;
                    cmd.tag_clear  = 1'b1;
                    cmd.walk_evict = 1'b1;
                    state_next     = ST_WRD;
                end
            end
            ST_CHECK: begin
                if (status.fits) begin
                    state_next = ST_PRD;
                end else if (status.from_newest) begin
                    cmd.retry_window = 1'b1;
                    state_next       = ST_SEARCH;
                end else begin
                    state_next = ST_FAIL;
                end
            end
            ST_FAIL: begin
                if (status.out_free) begin
                    cmd.fail_commit = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = KIND_REFUSED;
                    cmd.emit_last   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_PRD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_FRESH;
                state_next = ST_PLACE;
            end
            ST_PLACE: begin
                if (!status.tag_nz) begin
                    state_next = ST_COMMIT;
                end else if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_RELEASED;
                    cmd.emit_row  = 1'b1;
                    cmd.tag_clear = 1'b1;
                    state_next    = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit    = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ALLOCATED;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FRD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_WALK;
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!status.tag_nz || status.out_free) begin
                    cmd.emit      = status.tag_nz;
                    cmd.emit_kind = KIND_RELEASED;
                    cmd.emit_row  = 1'b1;
                    cmd.tag_clear = 1'b1;
                    if (status.walk_at_newest) begin
                        state_next = ST_DONEF;
                    end else begin
                        cmd.flush_step = 1'b1;
                        state_next     = ST_FRD;
                    end
                end
            end
            ST_DONEF: begin
                if (status.out_free) begin
                    cmd.flush_end = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DONE;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IRD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_INDEX;
                state_next = ST_IDX;
            end
            ST_IDX: begin
                if (status.bad_index) begin
                    if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_REFUSED;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (act_reg == ACT_QUERY) begin
                    if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_ADDRESS;
                        cmd.emit_row  = 1'b1;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (!status.tag_nz) begin
                    state_next = ST_IDONE;
                end else if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_RELEASED;
                    cmd.emit_row  = 1'b1;
                    cmd.tag_clear = 1'b1;
                    state_next    = ST_IDONE;
                end
            end
            ST_IDONE: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DONE;
                    cmd.emit_row  = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[design/rra_datapath.sv]
module rra_datapath
    import rra_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int ADDR_BITS = 32,
    parameter int TAG_BITS  = 16,
    parameter int IDX_W     = $clog2(NUM_SLOTS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SIZE_W-1:0]     in_size,
    input  logic [IDX_W-1:0]      in_slot_sel,
    input  logic [TAG_BITS-1:0]   in_user_tag,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output kind_t                 out_kind,
    output logic [IDX_W-1:0]      out_slot_sel,
    output logic [ADDR_BITS-1:0]  out_address,
    output logic [TAG_BITS-1:0]   out_user_tag,
    output logic                  out_last
);

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    logic [ADDR_BITS-1:0] min_addr_reg, max_addr_reg;
    logic [SHIFT_W-1:0]   align_reg, bnd_bits_reg;
    logic                 bnd_en_reg;
    logic [COUNT_W-1:0]   active_reg;

    logic [SIZE_W-1:0]   size_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic [CALC_W-1:0] lo_reg, sz_reg, search_reg, adj_reg;
    logic [IDX_W-1:0]  walk_reg, fresh_reg, oldest_reg, newest_reg;
    logic              walking_reg, from_newest_reg, ring_used_reg;

    logic [ADDR_BITS-1:0] mem_addr [NUM_SLOTS];
    logic [ADDR_BITS-1:0] mem_size [NUM_SLOTS];
    logic [TAG_BITS-1:0]  mem_tag  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] tag_valid_reg, live_reg;

    logic [IDX_W-1:0]     rd_row_reg;
    logic [ADDR_BITS-1:0] rd_addr_reg, rd_size_reg;
    logic [TAG_BITS-1:0]  rd_tag_reg;
    logic                 rd_live_reg;

    logic                 m_valid_reg;
    kind_t                m_kind_reg;
    logic [IDX_W-1:0]     m_idx_reg;
    logic [ADDR_BITS-1:0] m_addr_reg;
    logic [TAG_BITS-1:0]  m_tag_reg;
    logic                 m_last_reg;

    logic [CNT_W-1:0]  cnt;
    logic [CALC_W-1:0] amask, lo_ext, sz_ext, lo_round, sz_round, hi;
    logic [CALC_W-1:0] bnd, bmask, base, search_next, adj_next, row_addr, end_addr;
    logic [IDX_W:0]    fresh_inc, walk_inc;
    logic [IDX_W-1:0]  fresh_next, walk_next, rd_sel_idx;
    logic              out_free;

    always_comb begin
        if (active_reg == '0) begin
            cnt = CNT_W'(1);
        end else if (int'(active_reg) > NUM_SLOTS) begin
            cnt = CNT_W'(NUM_SLOTS);
        end else begin
            cnt = CNT_W'(active_reg);
        end
    end

    assign amask    = (CALC_W'(1) << align_reg) - CALC_W'(1);
    assign lo_ext   = CALC_W'(min_addr_reg);
    assign sz_ext   = CALC_W'(size_reg);
    assign lo_round = ((lo_ext & amask) != '0) ? ((lo_ext | amask) + CALC_W'(1)) : lo_ext;
    assign sz_round = ((sz_ext & amask) != '0) ? ((sz_ext | amask) + CALC_W'(1)) : sz_ext;
    assign hi       = CALC_W'(max_addr_reg);

    assign fresh_inc  = {1'b0, newest_reg} + (IDX_W+1)'(1);
    assign fresh_next = (!ring_used_reg || fresh_inc >= (IDX_W+1)'(cnt)) ?
                        '0 : fresh_inc[IDX_W-1:0];
    assign walk_inc   = {1'b0, walk_reg} + (IDX_W+1)'(1);
    assign walk_next  = (walk_inc >= (IDX_W+1)'(cnt)) ? '0 : walk_inc[IDX_W-1:0];

    assign search_next = from_newest_reg ?
                         (CALC_W'(rd_addr_reg) + CALC_W'(rd_size_reg)) : lo_reg;
    assign bnd         = CALC_W'(1) << bnd_bits_reg;
    assign bmask       = ~(bnd - CALC_W'(1));
    assign base        = search_reg & bmask;
    assign adj_next    = (bnd_en_reg && base != ((search_reg + sz_reg) & bmask)) ?
                         (base + bnd) : search_reg;
    assign row_addr    = CALC_W'(rd_addr_reg);
    assign end_addr    = adj_reg + sz_reg;

    always_comb begin
        unique case (cmd.rd_sel)
            RD_NEWEST: rd_sel_idx = newest_reg;
            RD_WALK:   rd_sel_idx = walk_reg;
            RD_FRESH:  rd_sel_idx = fresh_reg;
            RD_INDEX:  rd_sel_idx = idx_reg;
            default:   rd_sel_idx = walk_reg;
        endcase
    end

    assign out_free = !m_valid_reg || out_ready;

    assign status.ring_used      = ring_used_reg;
    assign status.too_large      = (lo_reg >= hi) || (sz_reg > hi - lo_reg);
    assign status.walking        = walking_reg;
    assign status.walk_hit       = (rd_row_reg == fresh_reg) ||
                                   (search_reg <= row_addr && end_addr > row_addr);
    assign status.tag_nz         = (rd_tag_reg != '0);
    assign status.fits           = (end_addr <= hi);
    assign status.from_newest    = from_newest_reg;
    assign status.walk_at_newest = (walk_reg == newest_reg);
    assign status.bad_index      = ((IDX_W+1)'(idx_reg) >= (IDX_W+1)'(cnt)) || !rd_live_reg;
    assign status.out_free       = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            size_reg <= in_size;
            idx_reg  <= in_slot_sel;
            tag_reg  <= in_user_tag;
        end
        if (cmd.prep) begin
            lo_reg    <= lo_round;
            sz_reg    <= sz_round;
            fresh_reg <= fresh_next;
        end
        if (cmd.calc_search) begin
            search_reg <= search_next;
        end
        if (cmd.calc_adj) begin
            adj_reg <= adj_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            mem_addr[fresh_reg] <= adj_reg[ADDR_BITS-1:0];
            mem_size[fresh_reg] <= sz_reg[ADDR_BITS-1:0];
            mem_tag[fresh_reg]  <= tag_reg;
        end
        if (cmd.rd_en) begin
            rd_row_reg  <= rd_sel_idx;
            rd_addr_reg <= mem_addr[rd_sel_idx];
            rd_size_reg <= mem_size[rd_sel_idx];
            rd_tag_reg  <= tag_valid_reg[rd_sel_idx] ? mem_tag[rd_sel_idx] : '0;
            rd_live_reg <= live_reg[rd_sel_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_addr_reg    <= '0;
            max_addr_reg    <= ADDR_BITS'(32'd65536);
            align_reg       <= '0;
            bnd_en_reg      <= 1'b0;
            bnd_bits_reg    <= '0;
            active_reg      <= COUNT_W'(16);
            ring_used_reg   <= 1'b0;
            oldest_reg      <= '0;
            newest_reg      <= '0;
            walk_reg        <= '0;
            walking_reg     <= 1'b0;
            from_newest_reg <= 1'b0;
            tag_valid_reg   <= '0;
            live_reg        <= '0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_MIN_ADDRESS:     min_addr_reg <= cfg_data[ADDR_BITS-1:0];
                    REG_MAX_ADDRESS:     max_addr_reg <= cfg_data[ADDR_BITS-1:0];
                    REG_ALIGN_BITS:      align_reg    <= cfg_data[SHIFT_W-1:0];
                    REG_BOUNDARY_ENABLE: bnd_en_reg   <= cfg_data[0];
                    REG_BOUNDARY_BITS:   bnd_bits_reg <= cfg_data[SHIFT_W-1:0];
                    REG_ACTIVE_BLOCKS: begin
                        active_reg    <= cfg_data[COUNT_W-1:0];
                        ring_used_reg <= 1'b0;
                        oldest_reg    <= '0;
                        newest_reg    <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.latch_in) begin
                walk_reg <= oldest_reg;
            end
            if (cmd.prep) begin
                walk_reg        <= oldest_reg;
                walking_reg     <= ring_used_reg;
                from_newest_reg <= ring_used_reg;
            end
            if (cmd.tag_clear) begin
                tag_valid_reg[rd_row_reg] <= 1'b0;
            end
            if (cmd.walk_evict) begin
                live_reg[rd_row_reg] <= 1'b0;
                if (walk_reg == newest_reg) begin
                    walking_reg <= 1'b0;
                end else begin
                    walk_reg <= walk_next;
                end
            end
            if (cmd.retry_window) begin
                from_newest_reg <= 1'b0;
            end
            if (cmd.fail_commit) begin
                if (walking_reg) begin
                    oldest_reg <= walk_reg;
                end else begin
                    ring_used_reg <= 1'b0;
                end
            end
            if (cmd.commit) begin
                tag_valid_reg[fresh_reg] <= 1'b1;
                live_reg[fresh_reg]      <= 1'b1;
                newest_reg               <= fresh_reg;
                oldest_reg               <= walking_reg ? walk_reg : fresh_reg;
                ring_used_reg            <= 1'b1;
            end
            if (cmd.flush_step) begin
                walk_reg <= walk_next;
            end
            if (cmd.flush_end) begin
                ring_used_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_kind_reg <= cmd.emit_kind;
            m_last_reg <= cmd.emit_last;
            if (cmd.emit_row) begin
                m_idx_reg <= rd_row_reg;
            end else if (cmd.emit_kind == KIND_ALLOCATED) begin
                m_idx_reg <= fresh_reg;
            end else begin
                m_idx_reg <= '0;
            end
            case (cmd.emit_kind)
                KIND_ALLOCATED: m_addr_reg <= adj_reg[ADDR_BITS-1:0];
                KIND_ADDRESS:   m_addr_reg <= rd_addr_reg;
                default:        m_addr_reg <= '0;
            endcase
            m_tag_reg <= (cmd.emit_kind == KIND_RELEASED) ? rd_tag_reg : '0;
        end
    end

    assign out_valid    = m_valid_reg;
    assign out_kind     = m_kind_reg;
    assign out_slot_sel = m_idx_reg;
    assign out_address  = m_addr_reg;
    assign out_user_tag = m_tag_reg;
    assign out_last     = m_last_reg;

endmodule

[design/ring_region_allocator_core.sv]
// Channel   Direction  Handshake             Contents
// s_        in         s_tvalid / s_tready   tuser action, tdata request fields
// m_        out        m_tvalid / m_tready   tuser kind, tlast, tdata result fields
// cfg_      in         cfg_valid / cfg_ready register index and write data
//
// Items are taken one at a time. Allocate retries once from the window start, and its
// eviction walk steps through the single read port of the slot store, as does the flush.
// Reset is synchronous with no clearing pass; tag and live bits clear at once.
// A stalled m_ side holds the walk whenever a further result is due.
module ring_region_allocator_core
    import rra_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int ADDR_BITS = 32,
    parameter int TAG_BITS  = 16,
    parameter int IDX_W     = $clog2(NUM_SLOTS),
    parameter int S_DATA_W  = ((SIZE_W + IDX_W + TAG_BITS + 7) / 8) * 8,
    parameter int M_DATA_W  = ((IDX_W + ADDR_BITS + TAG_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // size, slot, user_tag
    input  logic [ACT_W-1:0]      s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // result slot, address, user_tag_res
    output logic [KIND_W-1:0]     m_tuser,   // kind
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int M_USED_W = IDX_W + ADDR_BITS + TAG_BITS;

    dp_cmd_t              cmd;
    dp_status_t           status;
    kind_t                out_kind;
    logic [IDX_W-1:0]     out_idx;
    logic [ADDR_BITS-1:0] out_addr;
    logic [TAG_BITS-1:0]  out_tag;

    assign cfg_ready = 1'b1;

    rra_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (action_t'(s_tuser)),
        .in_ready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rra_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .ADDR_BITS (ADDR_BITS),
        .TAG_BITS  (TAG_BITS),
        .IDX_W     (IDX_W)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_size      (s_tdata[SIZE_W-1:0]),
        .in_slot_sel  (s_tdata[SIZE_W +: IDX_W]),
        .in_user_tag  (s_tdata[SIZE_W + IDX_W +: TAG_BITS]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (out_kind),
        .out_slot_sel (out_idx),
        .out_address  (out_addr),
        .out_user_tag (out_tag),
        .out_last     (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = M_DATA_W'({out_tag, out_addr, out_idx});

endmodule

[design/rra_checker.sv]
module rra_checker
    import rra_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int ADDR_BITS = 32,
    parameter int TAG_BITS  = 16,
    parameter int IDX_W     = $clog2(NUM_SLOTS),
    parameter int S_DATA_W  = ((SIZE_W + IDX_W + TAG_BITS + 7) / 8) * 8,
    parameter int M_DATA_W  = ((IDX_W + ADDR_BITS + TAG_BITS + 7) / 8) * 8
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_DATA_W-1:0]   s_tdata,
    input logic [ACT_W-1:0]      s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic [KIND_W-1:0]     m_tuser,
    input logic                  m_tlast,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_refused_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_REFUSED |-> m_tdata == '0 && m_tlast)
        else $error("refused result carries data or is not final");

    a_final_kinds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ALLOCATED || m_tuser == KIND_ADDRESS ||
                     m_tuser == KIND_DONE) |-> m_tlast)
        else $error("closing result without last");

endmodule

bind ring_region_allocator_core rra_checker #(
    .NUM_SLOTS (NUM_SLOTS),
    .ADDR_BITS (ADDR_BITS),
    .TAG_BITS  (TAG_BITS)
) u_rra_checker (.*);
